>>> src/vdn_pkg.sv
`default_nettype none

package vdn_pkg;

    localparam int ELEM_W     = 16;  // field width of u_elem / v_elem
    localparam int ELEM_MAX_W = 24;  // widest element the datapath supports
    localparam int ACC_W      = 46;
    localparam int ROOT_W     = 23;  // floor(sqrt(2^46 - 1)) < 2^23
    localparam int KIND_W     = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        NORM_L0   = 2'd0,
        NORM_L1   = 2'd1,
        NORM_L2   = 2'd2,
        NORM_LINF = 2'd3
    } norm_kind_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] u_elem;
        logic signed [ELEM_W-1:0] v_elem;
        logic                     last_elem;
    } vdn_in_t;

    typedef struct packed {
        logic [ACC_W-1:0] norm_value;
        logic             overflow;
    } vdn_out_t;

    // root unit status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } vdn_root_stat_t;

endpackage : vdn_pkg

`default_nettype wire

>>> src/vdn_isqrt.sv
`default_nettype none

// Digit-by-digit integer square root, two radicand bits per cycle.
module vdn_isqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [vdn_pkg::ACC_W-1:0]  radicand,
    output vdn_pkg::vdn_root_stat_t         status,
    output logic      [vdn_pkg::ROOT_W-1:0] root
);
    import vdn_pkg::*;

    localparam int BIT_W = ACC_W + 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] x_reg, x_next;
    logic [BIT_W-1:0] root_reg, root_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [BIT_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (start) begin
            busy_next = 1'b1;
            x_next    = radicand;
            root_next = '0;
            bit_next  = {1'b1, {ACC_W{1'b0}}};
        end else if (busy_reg) begin
            if ({2'b00, x_reg} >= trial) begin
                x_next    = x_reg - trial[ACC_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg[ROOT_W-1:0];

endmodule : vdn_isqrt

`default_nettype wire

>>> src/vector_distance_norm.sv
// vector_distance_norm
//
// Folds a stream of element pairs (u_elem, v_elem) into one norm of u - v.
// Input words arrive on s_valid / s_ready / s_data; the word flagged
// last_elem closes the vector and yields one result word on
// m_valid / m_ready / m_data (norm_value, overflow). Feed v_elem = 0 for a
// single-vector norm. norm_kind is written through cfg_valid / cfg_data
// (cfg_ready is always high); the user must write it only while no vector
// is in flight, which the block does not enforce; reset selects L2.
// Each word passes three steps (accept, square/select, add); the small
// sequencer drops s_ready after each accept until the fold is done and,
// after the last word, until its result is in the output register.
// For L0, L1 and L-infinity the result is registered after the last fold;
// L2 first runs the root unit, 24 iterations of compare and subtract.
// Runs longer than MAX_LEN, or sums past 2^46 - 1, pin the accumulator at
// all ones and set overflow for that vector.
//
// Reset (synchronous, aresetn low) clears accumulator, flag, count and any
// pending result. A stalled result holds in the output register; the next
// vector's words are still taken, only its own result waits for the slot.
`default_nettype none

module vector_distance_norm #(
    parameter int MAX_LEN    = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // element pairs in
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  vdn_pkg::vdn_in_t                 s_data,
    // norm out
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output vdn_pkg::vdn_out_t                m_data,
    // norm_kind register write
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [vdn_pkg::KIND_W-1:0]  cfg_data
);
    import vdn_pkg::*;

    localparam int EW     = ELEM_WIDTH;
    localparam int MAG_W  = EW + 1;                 // |u - v| <= 2^EW
    localparam int DIFF_W = EW + 2;
    localparam int TERM_W = 2 * MAG_W;
    localparam int SUM_W  = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 2);    // holds MAX_LEN + 1

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TERM   = 6'b000010,
        ST_FOLD   = 6'b000100,
        ST_RSTART = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    norm_kind_t        norm_kind_reg;

    // per-word working registers
    norm_kind_t        kind_reg, kind_next;
    logic              last_reg, last_next;
    logic              over_reg, over_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [TERM_W-1:0] term_reg, term_next;

    // vector state
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              sat_reg, sat_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    vdn_out_t          m_data_reg, m_data_next;

    // element decode
    logic [ELEM_MAX_W-1:0]    u_wide, v_wide;
    logic [EW-1:0]            u_m, v_m;
    logic signed [DIFF_W-1:0] u_s, v_s, diff;

    logic [SUM_W-1:0]  sum;
    logic              out_free;
    logic              accept;

    vdn_root_stat_t    root_stat;
    logic              root_start;
    logic [ROOT_W-1:0] root_val;

    vdn_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_reg),
        .status   (root_stat),
        .root     (root_val)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_kind_reg <= NORM_L2;
        end else if (cfg_valid) begin
            norm_kind_reg <= norm_kind_t'(cfg_data);
        end
    end

    // Elements are ELEM_WIDTH-bit two's complement taken from the field bits
    assign u_wide = ELEM_MAX_W'($unsigned(s_data.u_elem));
    assign v_wide = ELEM_MAX_W'($unsigned(s_data.v_elem));
    assign u_m    = u_wide[EW-1:0];
    assign v_m    = v_wide[EW-1:0];
    assign u_s    = DIFF_W'($signed(u_m));
    assign v_s    = DIFF_W'($signed(v_m));
    assign diff   = u_s - v_s;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        over_next    = over_reg;
        mag_next     = mag_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        root_start   = 1'b0;
        sum          = SUM_W'(acc_reg) + SUM_W'(term_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next = norm_kind_reg;
                    last_next = s_data.last_elem;
                    mag_next  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
                    // count saturates at MAX_LEN + 1
                    if (cnt_reg <= CNT_LIMIT) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    over_next  = (cnt_reg >= CNT_LIMIT);
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                case (kind_reg)
                    NORM_L0: term_next = TERM_W'(mag_reg != '0);
                    NORM_L2: term_next = mag_reg * mag_reg;
                    default: term_next = TERM_W'(mag_reg);
                endcase
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (over_reg) begin
                    acc_next = ACC_MAX;
                    sat_next = 1'b1;
                end else if (kind_reg == NORM_LINF) begin
                    if (SUM_W'(term_reg) > SUM_W'(acc_reg)) begin
                        acc_next = ACC_W'(term_reg);
                    end
                end else if (sum > SUM_W'(ACC_MAX)) begin
                    acc_next = ACC_MAX;
                    sat_next = 1'b1;
                end else begin
                    acc_next = sum[ACC_W-1:0];
                end
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (kind_reg == NORM_L2) begin
                    state_next = ST_RSTART;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RSTART: begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.norm_value = (kind_reg == NORM_L2) ?
                                             ACC_W'(root_val) : acc_reg;
                    m_data_next.overflow   = sat_reg;
                    acc_next   = '0;
                    sat_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            sat_reg     <= sat_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg   <= kind_next;
        last_reg   <= last_next;
        over_reg   <= over_next;
        mag_reg    <= mag_next;
        term_reg   <= term_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : vector_distance_norm

`default_nettype wire

>>> src/vdn_checker.sv
`default_nettype none

module vdn_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_valid,
    input wire logic         s_ready,
    input vdn_pkg::vdn_in_t  s_data,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input vdn_pkg::vdn_out_t m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed or dropped while stalled");

    // one word at a time: ready falls after every accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // a word that does not close the vector raises no result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_elem && !m_valid |=> !m_valid)
        else $error("result raised by a non-final word");

endmodule : vdn_checker

bind vector_distance_norm vdn_checker u_vdn_checker (.*);

`default_nettype wire

>>> test/vector_distance_norm_test.sv
`default_nettype none

// Stand-alone bench for vector_distance_norm.
// Driver and receiver change inputs on the falling edge. A single monitor
// samples every handshake on the rising edge. On each accepted input word
// the monitor runs the local norm model, and on each accepted result word
// it checks against the oldest expected norm.
module vector_distance_norm_test;

    import vdn_pkg::*;

    localparam int MAX_LEN    = 4096;
    localparam int RAND_ITEMS = 1000;
    localparam int SETTLE     = 40;    // settle time, longer than an L2 result takes
    localparam int STALL_MAX  = 5000;  // cycles with no handshake at all
    localparam int HOLD_LEN   = 400;   // long receiver hold-off

    localparam logic [63:0] ACC_TOP = 64'(ACC_MAX);

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #6 aclk = ~aclk;

    logic                s_valid   = 1'b0;
    logic                s_ready;
    vdn_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    vdn_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [KIND_W-1:0]   cfg_data  = '0;

    vector_distance_norm #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------
    vdn_in_t     pair_backlog[$];  // words still to be offered
    vdn_out_t    norm_due[$];      // expected norms, oldest first
    int          errors    = 0;
    bit          s_took    = 1'b0; // set by monitor when the word held is taken
    bit          calm      = 1'b0; // no idling on either side from here on
    bit          hold_req  = 1'b0; // ask the receiver for a long hold-off
    int          send_gap  = 0;
    int          recv_gap  = 0;
    int          hold_left = 0;
    int          quiet_cnt = 0;

    // local copy of the block's state
    norm_kind_t  kind_now  = NORM_L2;
    logic [63:0] acc_val   = '0;
    bit          sat_seen  = 1'b0;
    int          pair_cnt  = 0;

    // ------------------------------------------------------------------
    // norm model
    // ------------------------------------------------------------------
    function automatic void acc_add(logic [63:0] x);
        if (x > ACC_TOP - acc_val) begin
            acc_val  = ACC_TOP;
            sat_seen = 1'b1;
        end else begin
            acc_val = acc_val + x;
        end
    endfunction

    // floor(sqrt(x)), one result bit per step from the top
    function automatic logic [ACC_W-1:0] root_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        int          b;
        r = '0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r[ACC_W-1:0];
    endfunction

    // fold one element pair; returns 1 with the norm when the vector closes
    function automatic bit fold_pair(input vdn_in_t w, output vdn_out_t res);
        longint      du;
        longint      dv;
        longint      d;
        logic [63:0] mag;
        du  = $signed(w.u_elem);
        dv  = $signed(w.v_elem);
        d   = du - dv;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        res = '0;

        if (pair_cnt <= MAX_LEN) pair_cnt++;

        if (pair_cnt > MAX_LEN) begin
            // run too long: pinned at all ones until the vector ends
            acc_val  = ACC_TOP;
            sat_seen = 1'b1;
        end else begin
            case (kind_now)
                NORM_L0:   acc_add((mag != 0) ? 64'd1 : 64'd0);
                NORM_L1:   acc_add(mag);
                NORM_L2:   acc_add(mag * mag);
                NORM_LINF: if (mag > acc_val) acc_val = mag;
                default:   ;
            endcase
        end

        if (!w.last_elem) return 1'b0;

        res.norm_value = (kind_now == NORM_L2) ? root_floor(acc_val)
                                               : acc_val[ACC_W-1:0];
        res.overflow   = sat_seen;
        acc_val  = '0;
        sat_seen = 1'b0;
        pair_cnt = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // input driver: holds one word until taken, random gaps between words
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_in
        logic    offer;
        vdn_in_t word;
        offer = s_valid;
        word  = s_data;
        if (s_took) begin
            s_took = 1'b0;
            offer  = 1'b0;
        end
        if (!offer && aresetn) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pair_backlog.size() > 0) begin
                word  = pair_backlog.pop_front();
                offer = 1'b1;
                // the gap starts once this word has gone
                if (!calm && $urandom_range(0, 6) == 0)
                    send_gap = $urandom_range(1, 15);
            end
        end
        s_valid <= offer;
        s_data  <= word;
    end

    // ------------------------------------------------------------------
    // result receiver: stall bursts, quiet stretches, one long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_out
        logic rdy;
        rdy = 1'b1;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            rdy = 1'b0;
        end else if (quiet_cnt > 0) begin
            quiet_cnt--;
        end else if (!calm) begin
            case ($urandom_range(0, 9))
                0, 1:    recv_gap  = $urandom_range(1, 15);
                2:       quiet_cnt = $urandom_range(20, 80);
                default: ;
            endcase
        end
        m_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // monitor: prediction, checking and watchdog, all at the rising edge
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin : watch
        vdn_out_t got;
        vdn_out_t want;
        bit       closes;
        if (aresetn) begin
            idle_cycles++;

            if (cfg_valid && cfg_ready) begin
                kind_now    = norm_kind_t'(cfg_data);
                idle_cycles = 0;
            end

            if (m_valid && m_ready) begin
                idle_cycles = 0;
                got = m_data;
                if (norm_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %0d/%0b",
                             $time, got.norm_value, got.overflow);
                    errors++;
                end else begin
                    want = norm_due.pop_front();
                    if (got.norm_value !== want.norm_value) begin
                        $display("%0t: norm_value mismatch, expected %0d, got %0d",
                                 $time, want.norm_value, got.norm_value);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %0b, got %0b",
                                 $time, want.overflow, got.overflow);
                        errors++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                idle_cycles = 0;
                s_took      = 1'b1;
                closes      = fold_pair(s_data, want);
                if (closes) norm_due.push_back(want);
            end

            if (idle_cycles >= STALL_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_pair(logic [15:0] u, logic [15:0] v, bit last);
        vdn_in_t w;
        w.u_elem    = u;
        w.v_elem    = v;
        w.last_elem = last;
        pair_backlog.push_back(w);
    endtask

    // element mix: extremes, zero, small values, full range
    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 15));
            4:       return -16'($urandom_range(1, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // one vector of random pairs; close = 0 leaves it open for the next phase
    task automatic queue_vector(int len, bit close);
        logic [15:0] u;
        logic [15:0] v;
        int          k;
        for (k = 0; k < len; k++) begin
            u = pick_elem();
            // equal pairs exercise the zero-difference path
            v = ($urandom_range(0, 5) == 0) ? u : pick_elem();
            push_pair(u, v, close && (k == len - 1));
        end
    endtask

    // wait until nothing is in flight, then let the fold pipeline drain
    task automatic wait_idle();
        while (pair_backlog.size() != 0 || s_valid || norm_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_kind(norm_kind_t k);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int rand_count;
        int phase;
        int n_vec;
        int j;
        int len;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed: reset kind is L2
        push_pair(16'h7fff, 16'h8000, 1);   // largest difference, root 65535
        push_pair(16'h8000, 16'h7fff, 1);
        push_pair(16'h0000, 16'h0000, 1);   // single zero pair
        push_pair(16'h0100, 16'h0000, 0);
        push_pair(16'h0000, 16'h0100, 0);
        push_pair(16'h0080, 16'h0080, 1);

        set_kind(NORM_L0);
        push_pair(16'h0005, 16'h0005, 0);
        push_pair(16'h0001, 16'h0000, 0);
        push_pair(16'h8000, 16'h8000, 0);
        push_pair(16'h7fff, 16'h8000, 1);
        push_pair(16'h0000, 16'h0000, 1);

        set_kind(NORM_L1);
        push_pair(16'h7fff, 16'h8000, 0);
        push_pair(16'h8000, 16'h7fff, 1);
        push_pair(16'hffff, 16'h0001, 1);

        set_kind(NORM_LINF);
        push_pair(16'h0001, 16'h0002, 0);
        push_pair(16'h8000, 16'h7fff, 0);
        push_pair(16'h0003, 16'h0000, 1);
        push_pair(16'h0000, 16'h0000, 0);   // left open across a kind change

        set_kind(NORM_L1);
        push_pair(16'h0000, 16'h0004, 1);

        // ---- random phases, one kind each
        rand_count = 0;
        phase      = 0;
        while (rand_count < RAND_ITEMS) begin
            set_kind(norm_kind_t'($urandom_range(0, 3)));
            if (rand_count > RAND_ITEMS * 85 / 100) calm = 1'b1;
            n_vec = $urandom_range(2, 10);
            if (phase == 2) begin
                // plenty of words behind a stalled result register
                n_vec    = 30;
                hold_req = 1'b1;
            end
            for (j = 0; j < n_vec; j++) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
                queue_vector(len, !(j == n_vec - 1 && $urandom_range(0, 4) == 0));
                rand_count += len;
            end
            phase++;
        end

        // ---- drain and finish
        while (pair_backlog.size() != 0 || s_valid || norm_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE + 20) @(posedge aclk);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/vdn_pkg.sv
src/vdn_isqrt.sv
src/vector_distance_norm.sv
src/vdn_checker.sv
test/vector_distance_norm_test.sv
